[rtl/bgcm_pkg.sv]
// Shared types and constants of the breakpoint grid coordinate map.
`default_nettype none
package bgcm_pkg;

	localparam int VAL_W = 32;
	localparam int CFG_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int ACT_W = 2;
	localparam int AXIS_W = 2;
	localparam int IDX_W = 6;
	localparam int ST_W = 2;
	localparam int FRAC_BITS = 16;
	localparam int QBITS = 34;
	localparam int NUM_REGS = 3;

	localparam int MAX_POINTS_DEF = 64;
	localparam int AXES_DEF = 3;

	localparam logic [VAL_W-1:0] ONE_Q = 32'h0001_0000;
	localparam logic [VAL_W-1:0] ZERO_Q = 32'h0000_0000;
	localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_L2P = 2'd1;
	localparam logic [ACT_W-1:0] ACT_P2L = 2'd2;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_EXT = 2'd1;
	localparam logic [ST_W-1:0] ST_SAT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_POINTS_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINTS_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POINTS_Z = 2'd2;

	localparam logic [CFG_W-1:0] POINTS_RESET = 7'd2;

	typedef enum logic [1:0] {KIND_NOP, KIND_WR, KIND_L2P, KIND_P2L} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [AXIS_W-1:0] axis;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [ST_W-1:0] status;
	} res_t;

endpackage
`default_nettype wire

[rtl/bgcm_ram.sv]
// Single-port RAM with registered read.
`default_nettype none
module bgcm_ram #(
	parameter int W = 32,
	parameter int DEPTH = 192
) (
	input wire logic clk,
	input wire logic en,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [W-1:0] wdata,
	output logic [W-1:0] rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule
`default_nettype wire

[rtl/bgcm_fifo.sv]
// Small first-in first-out queue between the block's parts.
`default_nettype none
module bgcm_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic pop,
	input wire logic [W-1:0] wdata,
	output logic [W-1:0] rdata,
	output logic full,
	output logic empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0] mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/bgcm_front.sv]
// Front part: point count registers and classification of incoming items.
`default_nettype none
module bgcm_front #(
	parameter int MAX_POINTS = bgcm_pkg::MAX_POINTS_DEF,
	parameter int AXES = bgcm_pkg::AXES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [bgcm_pkg::ACT_W-1:0] action,
	input wire logic [bgcm_pkg::AXIS_W-1:0] axis,
	input wire logic [bgcm_pkg::IDX_W-1:0] point_index,
	input wire logic [bgcm_pkg::VAL_W-1:0] value_in,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [bgcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [bgcm_pkg::CFG_W-1:0] cfg_data,
	output bgcm_pkg::cmd_t cmd,
	output logic [bgcm_pkg::CFG_W-1:0] pts [bgcm_pkg::NUM_REGS]
);

	logic [bgcm_pkg::CFG_W-1:0] pts_q [bgcm_pkg::NUM_REGS];

	assign cfg_ready = 1'b1;
	assign pts = pts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q[0] <= bgcm_pkg::POINTS_RESET;
			pts_q[1] <= bgcm_pkg::POINTS_RESET;
			pts_q[2] <= bgcm_pkg::POINTS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				bgcm_pkg::REG_POINTS_X: pts_q[0] <= cfg_data;
				bgcm_pkg::REG_POINTS_Y: pts_q[1] <= cfg_data;
				bgcm_pkg::REG_POINTS_Z: pts_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cmd.axis = axis;
		cmd.idx = point_index;
		cmd.value = value_in;
		cmd.kind = bgcm_pkg::KIND_NOP;
		if (32'(axis) < AXES) begin
			case (action)
				bgcm_pkg::ACT_WRITE: begin
					if (32'(point_index) < MAX_POINTS) begin
						cmd.kind = bgcm_pkg::KIND_WR;
					end
				end
				bgcm_pkg::ACT_L2P: cmd.kind = bgcm_pkg::KIND_L2P;
				bgcm_pkg::ACT_P2L: cmd.kind = bgcm_pkg::KIND_P2L;
				default: cmd.kind = bgcm_pkg::KIND_NOP;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/bgcm_back.sv]
// Back part: table access, search, shared multiplier and serial divider.
`default_nettype none
module bgcm_back #(
	parameter int MAX_POINTS = bgcm_pkg::MAX_POINTS_DEF,
	parameter int AXES = bgcm_pkg::AXES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire bgcm_pkg::cmd_t cmd,
	input wire logic cmd_empty,
	output logic cmd_pop,
	input wire logic [bgcm_pkg::CFG_W-1:0] pts [bgcm_pkg::NUM_REGS],
	input wire logic res_full,
	output logic res_push,
	output bgcm_pkg::res_t res
);

	localparam int NW = $clog2(MAX_POINTS + 1);
	localparam int DEPTH = AXES * MAX_POINTS;
	localparam int AW = $clog2(DEPTH);
	localparam int PW = NW + 17;
	localparam int QB = bgcm_pkg::QBITS;
	localparam int CNTW = $clog2(QB);

	typedef enum logic [4:0] {
		S_IDLE, S_WR, S_RD0, S_RD1, S_RD2, S_SCAN, S_PA, S_PB, S_PC,
		S_LW, S_LF, S_LG, S_PM1, S_PM2, S_PM3, S_PM4, S_DV0, S_DV1, S_DIV, S_DVF, S_OUT
	} state_t;

	state_t st_q;
	bgcm_pkg::kind_t kind_q;
	logic [bgcm_pkg::AXIS_W-1:0] axis_q;
	logic [bgcm_pkg::IDX_W-1:0] idx_q;
	logic signed [31:0] x_q;
	logic [NW-1:0] n_q;
	logic signed [31:0] c0_q;
	logic signed [31:0] a_q;
	logic signed [31:0] base_q;
	logic [NW-1:0] k_q;
	logic [NW-1:0] chk_q;
	logic chkv_q;
	logic [NW-1:0] pi_q;
	logic [16:0] f_q;
	logic signed [32:0] d_q;
	logic signed [32:0] ma_q;
	logic signed [32:0] mb_q;
	logic signed [65:0] prod_q;
	logic signed [51:0] rq_q;
	logic signed [63:0] num_q;
	logic signed [63:0] den_q;
	logic neg_q;
	logic [63:0] an_q;
	logic [63:0] ad_q;
	logic [63:0] rem_q;
	logic [QB-1:0] dq_q;
	logic [CNTW-1:0] cnt_q;
	logic ext_q;
	bgcm_pkg::res_t res_q;

	logic ram_en;
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0] rdata;
	logic signed [31:0] rd_s;
	logic [bgcm_pkg::CFG_W-1:0] praw;
	logic [NW-1:0] n_new;
	logic [PW-1:0] p;
	logic [NW-1:0] ic;
	logic [NW-1:0] fnd;
	logic fnd_v;
	logic [NW-1:0] ic2;
	logic signed [32:0] diff;
	logic signed [32:0] span;
	logic [65:0] pmag;
	logic [50:0] pq;
	logic signed [67:0] lsum;
	logic [63:0] nsum;
	logic [64:0] r2;
	logic r_ge;

	function automatic logic [AW-1:0] addr_of(input logic [1:0] ax, input logic [NW-1:0] k);
		addr_of = AW'(32'(ax) * MAX_POINTS + 32'(k));
	endfunction

	bgcm_ram #(.W(bgcm_pkg::VAL_W), .DEPTH(DEPTH)) u_ram (
		.clk(clk),
		.en(ram_en),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(x_q),
		.rdata(rdata)
	);

	assign rd_s = $signed(rdata);
	assign cmd_pop = (st_q == S_IDLE) && !cmd_empty && !res_full;
	assign res_push = (st_q == S_OUT);
	assign res = res_q;

	always_comb begin
		ram_en = 1'b0;
		ram_we = 1'b0;
		ram_addr = addr_of(axis_q, '0);
		case (st_q)
			S_WR: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
				ram_addr = AW'(32'(axis_q) * MAX_POINTS + 32'(idx_q));
			end
			S_RD0: ram_en = 1'b1;
			S_RD1: begin
				ram_en = 1'b1;
				ram_addr = addr_of(axis_q, n_q - 1'b1);
			end
			S_SCAN: begin
				ram_en = (k_q < n_q);
				ram_addr = addr_of(axis_q, k_q);
			end
			S_PA: begin
				ram_en = 1'b1;
				ram_addr = addr_of(axis_q, pi_q);
			end
			S_PB: begin
				ram_en = 1'b1;
				ram_addr = addr_of(axis_q, pi_q + 1'b1);
			end
			default: ;
		endcase
	end

	always_comb begin
		praw = pts[cmd.axis];
		if (praw < bgcm_pkg::CFG_W'(2)) begin
			n_new = NW'(2);
		end else if (32'(praw) > MAX_POINTS) begin
			n_new = NW'(MAX_POINTS);
		end else begin
			n_new = NW'(praw);
		end

		p = PW'(x_q[16:0]) * PW'(n_q - 1'b1);
		if (p[PW-1:16] > (NW + 1)'(n_q - NW'(2))) begin
			ic = n_q - NW'(2);
		end else begin
			ic = NW'(p[PW-1:16]);
		end

		fnd_v = 1'b0;
		fnd = chk_q;
		if (chkv_q) begin
			if (rd_s >= x_q) begin
				fnd_v = 1'b1;
			end else if (chk_q == n_q - 1'b1) begin
				fnd_v = 1'b1;
				fnd = n_q;
			end
		end
		ic2 = fnd;
		if (ic2 == '0) begin
			ic2 = NW'(1);
		end
		if (ic2 > n_q - 1'b1) begin
			ic2 = n_q - 1'b1;
		end

		diff = {rd_s[31], rd_s} - {a_q[31], a_q};
		span = {rd_s[31], rd_s} - {c0_q[31], c0_q};
		pmag = prod_q[65] ? 66'(-prod_q) : 66'(prod_q);
		pq = 51'((pmag + 66'(32768)) >> bgcm_pkg::FRAC_BITS);
		lsum = 68'(base_q) + 68'(rq_q);
		nsum = an_q + (ad_q >> 1);
		r2 = {rem_q, dq_q[QB-1]};
		r_ge = (r2 >= {1'b0, ad_q});
	end

	always_ff @(posedge clk) begin
		prod_q <= ma_q * mb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (!cmd_empty && !res_full) begin
						kind_q <= cmd.kind;
						axis_q <= cmd.axis;
						idx_q <= cmd.idx;
						x_q <= $signed(cmd.value);
						n_q <= n_new;
						ext_q <= 1'b0;
						res_q <= '{value: bgcm_pkg::ZERO_Q, status: bgcm_pkg::ST_OK};
						case (cmd.kind)
							bgcm_pkg::KIND_NOP: st_q <= S_OUT;
							bgcm_pkg::KIND_WR: st_q <= S_WR;
							default: st_q <= S_RD0;
						endcase
					end
				end
				S_WR: st_q <= S_OUT;
				S_RD0: st_q <= S_RD1;
				S_RD1: begin
					c0_q <= rd_s;
					st_q <= S_RD2;
				end
				S_RD2: begin
					if (kind_q == bgcm_pkg::KIND_L2P) begin
						if (x_q < 0 || x_q > $signed(bgcm_pkg::ONE_Q)) begin
							ext_q <= 1'b1;
							ma_q <= {x_q[31], x_q};
							mb_q <= span;
							base_q <= c0_q;
							st_q <= S_LW;
						end else begin
							pi_q <= ic;
							f_q <= 17'(p - PW'({ic, 16'b0}));
							st_q <= S_PA;
						end
					end else begin
						if (x_q < c0_q || x_q > rd_s) begin
							ext_q <= 1'b1;
							num_q <= (64'(signed'({x_q[31], x_q} - {c0_q[31], c0_q})))
								<<< bgcm_pkg::FRAC_BITS;
							den_q <= 64'(span);
							st_q <= S_DV0;
						end else begin
							k_q <= '0;
							chkv_q <= 1'b0;
							st_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					k_q <= k_q + 1'b1;
					chk_q <= k_q;
					chkv_q <= (k_q < n_q);
					if (fnd_v) begin
						pi_q <= ic2 - 1'b1;
						st_q <= S_PA;
					end
				end
				S_PA: st_q <= S_PB;
				S_PB: begin
					a_q <= rd_s;
					st_q <= S_PC;
				end
				S_PC: begin
					mb_q <= diff;
					if (kind_q == bgcm_pkg::KIND_L2P) begin
						ma_q <= 33'(f_q);
						base_q <= a_q;
						st_q <= S_LW;
					end else begin
						d_q <= diff;
						ma_q <= 33'(pi_q);
						st_q <= S_PM1;
					end
				end
				S_LW: st_q <= S_LF;
				S_LF: begin
					rq_q <= prod_q[65] ? -52'(pq) : 52'(pq);
					st_q <= S_LG;
				end
				S_LG: begin
					if (lsum > 68'(signed'(bgcm_pkg::VAL_MAX))) begin
						res_q <= '{value: bgcm_pkg::VAL_MAX, status: bgcm_pkg::ST_SAT};
					end else if (lsum < 68'(signed'(bgcm_pkg::VAL_MIN))) begin
						res_q <= '{value: bgcm_pkg::VAL_MIN, status: bgcm_pkg::ST_SAT};
					end else begin
						res_q <= '{value: lsum[31:0],
							status: ext_q ? bgcm_pkg::ST_EXT : bgcm_pkg::ST_OK};
					end
					st_q <= S_OUT;
				end
				S_PM1: st_q <= S_PM2;
				S_PM2: begin
					num_q <= (prod_q[63:0] + 64'(signed'({x_q[31], x_q} - {a_q[31], a_q})))
						<<< bgcm_pkg::FRAC_BITS;
					ma_q <= d_q;
					mb_q <= 33'(n_q - 1'b1);
					st_q <= S_PM3;
				end
				S_PM3: st_q <= S_PM4;
				S_PM4: begin
					den_q <= prod_q[63:0];
					st_q <= S_DV0;
				end
				S_DV0: begin
					if (den_q == '0) begin
						res_q <= '{value: num_q[63] ? bgcm_pkg::VAL_MIN : bgcm_pkg::VAL_MAX,
							status: bgcm_pkg::ST_SAT};
						st_q <= S_OUT;
					end else begin
						neg_q <= num_q[63] ^ den_q[63];
						an_q <= num_q[63] ? 64'(-num_q) : 64'(num_q);
						ad_q <= den_q[63] ? 64'(-den_q) : 64'(den_q);
						st_q <= S_DV1;
					end
				end
				S_DV1: begin
					if ((nsum >> QB) >= ad_q) begin
						res_q <= '{value: neg_q ? bgcm_pkg::VAL_MIN : bgcm_pkg::VAL_MAX,
							status: bgcm_pkg::ST_SAT};
						st_q <= S_OUT;
					end else begin
						rem_q <= nsum >> QB;
						dq_q <= nsum[QB-1:0];
						cnt_q <= '0;
						st_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= r_ge ? 64'(r2 - {1'b0, ad_q}) : r2[63:0];
					dq_q <= {dq_q[QB-2:0], r_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(QB - 1)) begin
						st_q <= S_DVF;
					end
				end
				S_DVF: begin
					if (!neg_q && dq_q > QB'(bgcm_pkg::VAL_MAX)) begin
						res_q <= '{value: bgcm_pkg::VAL_MAX, status: bgcm_pkg::ST_SAT};
					end else if (neg_q && dq_q > QB'(bgcm_pkg::VAL_MIN)) begin
						res_q <= '{value: bgcm_pkg::VAL_MIN, status: bgcm_pkg::ST_SAT};
					end else begin
						res_q <= '{value: neg_q ? 32'(-dq_q) : dq_q[31:0],
							status: ext_q ? bgcm_pkg::ST_EXT : bgcm_pkg::ST_OK};
					end
					st_q <= S_OUT;
				end
				S_OUT: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/breakpoint_grid_coordinate_map.sv]
// Top level of the breakpoint grid coordinate map.
//
// Channel   Handshake            Payload
// input     push / full          action, axis, point_index, value_in
// result    empty / pop          value_out, status
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A physical to logical query inside the table searches it by a linear scan through the one
// RAM port; physical to logical queries use a divider that yields one quotient bit per cycle.
// Items are worked one at a time by the back part.
// Reset is asynchronous and active low; the breakpoint table holds no reset value.
// A four-beat command queue and a two-beat result queue let either side stall freely.
`default_nettype none
module breakpoint_grid_coordinate_map #(
	parameter int MAX_POINTS = bgcm_pkg::MAX_POINTS_DEF,
	parameter int AXES = bgcm_pkg::AXES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [bgcm_pkg::ACT_W-1:0] action,
	input wire logic [bgcm_pkg::AXIS_W-1:0] axis,
	input wire logic [bgcm_pkg::IDX_W-1:0] point_index,
	input wire logic [bgcm_pkg::VAL_W-1:0] value_in,
	output logic empty,
	input wire logic pop,
	output logic [bgcm_pkg::VAL_W-1:0] value_out,
	output logic [bgcm_pkg::ST_W-1:0] status,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [bgcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [bgcm_pkg::CFG_W-1:0] cfg_data
);

	bgcm_pkg::cmd_t cmd_in;
	bgcm_pkg::cmd_t cmd_out;
	logic [$bits(bgcm_pkg::cmd_t)-1:0] cmd_raw;
	logic cmd_empty;
	logic cmd_pop;
	logic [bgcm_pkg::CFG_W-1:0] pts [bgcm_pkg::NUM_REGS];
	logic res_full;
	logic res_push;
	bgcm_pkg::res_t res_in;
	bgcm_pkg::res_t res_out;
	logic [$bits(bgcm_pkg::res_t)-1:0] res_raw;

	bgcm_front #(.MAX_POINTS(MAX_POINTS), .AXES(AXES)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.action(action),
		.axis(axis),
		.point_index(point_index),
		.value_in(value_in),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd_in),
		.pts(pts)
	);

	bgcm_fifo #(.W($bits(bgcm_pkg::cmd_t)), .DEPTH(4)) u_cmd_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(cmd_pop),
		.wdata(cmd_in),
		.rdata(cmd_raw),
		.full(full),
		.empty(cmd_empty)
	);

	assign cmd_out = bgcm_pkg::cmd_t'(cmd_raw);

	bgcm_back #(.MAX_POINTS(MAX_POINTS), .AXES(AXES)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_out),
		.cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop),
		.pts(pts),
		.res_full(res_full),
		.res_push(res_push),
		.res(res_in)
	);

	bgcm_fifo #(.W($bits(bgcm_pkg::res_t)), .DEPTH(2)) u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.pop(pop),
		.wdata(res_in),
		.rdata(res_raw),
		.full(res_full),
		.empty(empty)
	);

	assign res_out = bgcm_pkg::res_t'(res_raw);
	assign value_out = res_out.value;
	assign status = res_out.status;

endmodule
`default_nettype wire

[rtl/bgcm_chk.sv]
// Port-level checker of the breakpoint grid coordinate map and its bind.
`default_nettype none
module bgcm_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic full,
	input wire logic [bgcm_pkg::ACT_W-1:0] action,
	input wire logic [bgcm_pkg::AXIS_W-1:0] axis,
	input wire logic [bgcm_pkg::IDX_W-1:0] point_index,
	input wire logic [bgcm_pkg::VAL_W-1:0] value_in,
	input wire logic empty,
	input wire logic pop,
	input wire logic [bgcm_pkg::VAL_W-1:0] value_out,
	input wire logic [bgcm_pkg::ST_W-1:0] status,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [bgcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [bgcm_pkg::CFG_W-1:0] cfg_data
);

	logic [7:0] open_q;
	logic acc_in;
	logic acc_out;

	assign acc_in = push && !full;
	assign acc_out = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (acc_in && !acc_out) begin
			open_q <= open_q + 1'b1;
		end else if (acc_out && !acc_in) begin
			open_q <= open_q - 1'b1;
		end
	end

	a_empty_in_reset: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result queue not empty during reset");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> open_q != 8'd0)
		else $error("result shown with no item outstanding");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status == bgcm_pkg::ST_OK || status == bgcm_pkg::ST_EXT ||
			status == bgcm_pkg::ST_SAT))
		else $error("undefined status code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(value_out) && $stable(status))
		else $error("waiting result changed");

endmodule

bind breakpoint_grid_coordinate_map bgcm_chk u_bgcm_chk (.*);
`default_nettype wire

[verif/tb_breakpoint_grid_coordinate_map.sv]
// Self-checking testbench of the breakpoint grid coordinate map with its own predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_breakpoint_grid_coordinate_map;

	localparam logic [bgcm_pkg::ACT_W-1:0] ACT_NOP = 2'd3;
	localparam logic [bgcm_pkg::AXIS_W-1:0] AX_X = 2'd0;
	localparam logic [bgcm_pkg::AXIS_W-1:0] AX_Y = 2'd1;
	localparam logic [bgcm_pkg::AXIS_W-1:0] AX_Z = 2'd2;
	localparam logic [bgcm_pkg::AXIS_W-1:0] AX_BAD = 2'd3;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int NPTS = bgcm_pkg::MAX_POINTS_DEF;

	typedef struct {
		logic [bgcm_pkg::ACT_W-1:0] act;
		logic [bgcm_pkg::AXIS_W-1:0] ax;
		logic [bgcm_pkg::IDX_W-1:0] idx;
		logic [bgcm_pkg::VAL_W-1:0] val;
		bit known;
		logic [bgcm_pkg::VAL_W-1:0] want_val;
		logic [bgcm_pkg::ST_W-1:0] want_st;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [bgcm_pkg::ACT_W-1:0] action = '0;
	logic [bgcm_pkg::AXIS_W-1:0] axis = '0;
	logic [bgcm_pkg::IDX_W-1:0] point_index = '0;
	logic [bgcm_pkg::VAL_W-1:0] value_in = '0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [bgcm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bgcm_pkg::CFG_W-1:0] cfg_data = '0;
	logic full, empty, cfg_ready;
	logic [bgcm_pkg::VAL_W-1:0] value_out;
	logic [bgcm_pkg::ST_W-1:0] status;

	logic [bgcm_pkg::VAL_W-1:0] grid [0:bgcm_pkg::AXES_DEF*NPTS-1];
	bit written [0:bgcm_pkg::AXES_DEF*NPTS-1];
	logic [bgcm_pkg::CFG_W-1:0] points [0:bgcm_pkg::NUM_REGS-1];
	bgcm_pkg::res_t pending_q[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int hold_count = 0;
	logic long_hold = 1'b0;
	logic steady = 1'b0;
	int rx_gap = 0;

	breakpoint_grid_coordinate_map u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.axis(axis), .point_index(point_index), .value_in(value_in), .empty(empty),
		.pop(pop), .value_out(value_out), .status(status), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int used_points(input int ax);
		int n;
		n = points[ax];
		if (n < 2) n = 2;
		if (n > NPTS) n = NPTS;
		return n;
	endfunction

	function automatic longint knot(input int ax, input int k);
		return longint'(signed'(grid[ax*NPTS+k]));
	endfunction

	function automatic longint div_nearest(input longint num, input longint den);
		longint unsigned an, ad, q;
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		q = (an + ad / 2) / ad;
		return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint div_guarded(input longint num, input longint den,
			inout bit sat);
		if (den == 0) begin
			sat = 1;
			return num < 0 ? -64'sd2147483648 : 64'sd2147483647;
		end
		return div_nearest(num, den);
	endfunction

	// Updates the table for writes and returns the mapped coordinate for queries.
	function automatic bgcm_pkg::res_t map_item(input logic [bgcm_pkg::ACT_W-1:0] act,
			input logic [bgcm_pkg::AXIS_W-1:0] ax, input logic [bgcm_pkg::IDX_W-1:0] idx,
			input logic [bgcm_pkg::VAL_W-1:0] val);
		bgcm_pkg::res_t r;
		int n, i;
		longint x, c0, cn, a, d, p, f, res;
		bit ext, sat;
		r.value = bgcm_pkg::ZERO_Q;
		r.status = bgcm_pkg::ST_OK;
		ext = 0;
		sat = 0;
		if (ax == AX_BAD || act == ACT_NOP) return r;
		if (act == bgcm_pkg::ACT_WRITE) begin
			grid[ax*NPTS+idx] = val;
			written[ax*NPTS+idx] = 1;
			return r;
		end
		n = used_points(ax);
		x = longint'(signed'(val));
		c0 = knot(ax, 0);
		cn = knot(ax, n - 1);
		if (act == bgcm_pkg::ACT_L2P) begin
			if (x < 0 || x > 65536) begin
				ext = 1;
				res = c0 + div_nearest(x * (cn - c0), 65536);
			end else begin
				p = x * (n - 1);
				i = int'(p >>> 16);
				if (i > n - 2) i = n - 2;
				f = p - longint'(i) * 65536;
				a = knot(ax, i);
				res = a + div_nearest(f * (knot(ax, i + 1) - a), 65536);
			end
		end else if (x < c0 || x > cn) begin
			ext = 1;
			res = div_guarded((x - c0) * 65536, cn - c0, sat);
		end else begin
			i = n;
			for (int k = 0; k < n; k++) begin
				if (knot(ax, k) >= x && i == n) i = k;
			end
			if (i < 1) i = 1;
			if (i > n - 1) i = n - 1;
			a = knot(ax, i - 1);
			d = knot(ax, i) - a;
			res = div_guarded((longint'(i - 1) * d + (x - a)) * 65536,
				d * (n - 1), sat);
		end
		if (res > 64'sd2147483647) begin
			res = 64'sd2147483647;
			sat = 1;
		end else if (res < -64'sd2147483648) begin
			res = -64'sd2147483648;
			sat = 1;
		end
		r.value = res[31:0];
		r.status = sat ? bgcm_pkg::ST_SAT : (ext ? bgcm_pkg::ST_EXT : bgcm_pkg::ST_OK);
		return r;
	endfunction

	function automatic bit axis_ready(input int ax);
		for (int k = 0; k < used_points(ax); k++) begin
			if (!written[ax*NPTS+k]) return 0;
		end
		return 1;
	endfunction

	task automatic send_beat(input row_t row);
		bgcm_pkg::res_t r;
		push <= 1'b1;
		action <= row.act;
		axis <= row.ax;
		point_index <= row.idx;
		value_in <= row.val;
		do @(posedge clk); while (full);
		r = map_item(row.act, row.ax, row.idx, row.val);
		if (row.known) begin
			r.value = row.want_val;
			r.status = row.want_st;
		end
		pending_q.push_back(r);
		if (!steady && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
			else repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic send(input logic [bgcm_pkg::ACT_W-1:0] act,
			input logic [bgcm_pkg::AXIS_W-1:0] ax,
			input logic [bgcm_pkg::IDX_W-1:0] idx, input logic [bgcm_pkg::VAL_W-1:0] val);
		row_t row;
		row = '{act, ax, idx, val, 0, bgcm_pkg::ZERO_Q, bgcm_pkg::ST_OK};
		send_beat(row);
	endtask

	task automatic write_points(input logic [bgcm_pkg::CFG_IDX_W-1:0] idx,
			input logic [bgcm_pkg::CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		points[idx] = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_axes(input bit extreme);
		longint v;
		for (int ax = 0; ax < bgcm_pkg::AXES_DEF; ax++) begin
			v = extreme ? -64'sd2147483648 : longint'($urandom_range(0, 1 << 30)) - (1 << 30);
			for (int k = 0; k < used_points(ax); k++) begin
				send(bgcm_pkg::ACT_WRITE, bgcm_pkg::AXIS_W'(ax), bgcm_pkg::IDX_W'(k), v[31:0]);
				v += extreme ? $urandom_range(1 << 20, 1 << 26) :
					($urandom_range(0, 1) ? $urandom_range(1, 4096) : $urandom_range(1, 1 << 24));
			end
		end
	endtask

	task automatic random_item();
		int ax, n, k, pick;
		longint lo, hi, x;
		ax = $urandom_range(0, 2);
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			send(bgcm_pkg::ACT_W'($urandom_range(0, 3)), AX_BAD, bgcm_pkg::IDX_W'($urandom),
				$urandom);
		end else if (pick < 10) begin
			send(ACT_NOP, bgcm_pkg::AXIS_W'(ax), bgcm_pkg::IDX_W'($urandom), $urandom);
		end else if (pick < 20 || !axis_ready(ax)) begin
			send(bgcm_pkg::ACT_WRITE, bgcm_pkg::AXIS_W'(ax), bgcm_pkg::IDX_W'($urandom),
				$urandom);
		end else if (pick < 60) begin
			k = $urandom_range(0, 9);
			x = k < 6 ? longint'($urandom_range(0, 65536)) :
				k < 8 ? longint'($urandom_range(65537, 400000)) - ($urandom_range(0, 1) ? 0 : 465537)
				: longint'(signed'($urandom));
			send(bgcm_pkg::ACT_L2P, bgcm_pkg::AXIS_W'(ax), bgcm_pkg::IDX_W'($urandom), x[31:0]);
		end else begin
			n = used_points(ax);
			k = $urandom_range(0, n - 2);
			lo = knot(ax, k);
			hi = knot(ax, k + 1);
			pick = $urandom_range(0, 9);
			if (pick < 6 && hi >= lo) x = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
			else if (pick < 8) x = knot(ax, $urandom_range(0, 1) ? 0 : n - 1) +
				longint'($urandom_range(0, 200)) - 100;
			else x = longint'(signed'($urandom));
			send(bgcm_pkg::ACT_P2L, bgcm_pkg::AXIS_W'(ax), bgcm_pkg::IDX_W'($urandom), x[31:0]);
		end
	endtask

	always @(posedge clk) begin
		bgcm_pkg::res_t want;
		if (pop && !empty) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected beat: value_out %h status %0d",
					value_out, status);
			end else begin
				want = pending_q.pop_front();
				if (value_out !== want.value || status !== want.status) begin
					mismatches++;
					if (mismatches <= 10) $display(
						"Result beat: expected value_out %h status %0d, got %h status %0d",
						want.value, want.status, value_out, status);
				end
			end
		end
		if (long_hold && hold_count < HOLD_CYCLES) begin
			hold_count++;
			pop <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			if (!steady && $urandom_range(0, 3) == 0)
				rx_gap = $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3);
		end
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		logic [bgcm_pkg::CFG_W-1:0] setups [0:6][0:2];
		for (int k = 0; k < bgcm_pkg::NUM_REGS; k++) points[k] = bgcm_pkg::POINTS_RESET;
		setups = '{'{2, 2, 2}, '{64, 2, 3}, '{0, 1, 127}, '{7, 33, 9}, '{65, 2, 3},
			'{3, 5, 9}, '{12, 4, 20}};
		rows = '{
			'{bgcm_pkg::ACT_WRITE, AX_X, 0, 32'hFFFF_0000, 1, bgcm_pkg::ZERO_Q, bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_WRITE, AX_X, 1, bgcm_pkg::ONE_Q, 1, bgcm_pkg::ZERO_Q, bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_WRITE, AX_Y, 0, bgcm_pkg::VAL_MIN, 1, bgcm_pkg::ZERO_Q,
				bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_WRITE, AX_Y, 1, bgcm_pkg::VAL_MAX, 1, bgcm_pkg::ZERO_Q,
				bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_WRITE, AX_Z, 0, bgcm_pkg::ZERO_Q, 1, bgcm_pkg::ZERO_Q, bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_WRITE, AX_Z, 1, bgcm_pkg::ZERO_Q, 1, bgcm_pkg::ZERO_Q, bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_WRITE, AX_BAD, 5, 32'h1234_5678, 1, bgcm_pkg::ZERO_Q,
				bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_WRITE, AX_X, 63, 32'h0000_007B, 1, bgcm_pkg::ZERO_Q, bgcm_pkg::ST_OK},
			'{ACT_NOP, AX_X, 0, 32'hFFFF_FFFF, 1, bgcm_pkg::ZERO_Q, bgcm_pkg::ST_OK},
			'{ACT_NOP, AX_BAD, 63, bgcm_pkg::ZERO_Q, 1, bgcm_pkg::ZERO_Q, bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_L2P, AX_X, 0, bgcm_pkg::ZERO_Q, 1, 32'hFFFF_0000, bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_L2P, AX_X, 0, bgcm_pkg::ONE_Q, 1, bgcm_pkg::ONE_Q, bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_L2P, AX_X, 0, 32'h0000_8000, 1, bgcm_pkg::ZERO_Q, bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_L2P, AX_X, 0, bgcm_pkg::VAL_MAX, 1, bgcm_pkg::VAL_MAX,
				bgcm_pkg::ST_SAT},
			'{bgcm_pkg::ACT_L2P, AX_X, 0, bgcm_pkg::VAL_MIN, 1, bgcm_pkg::VAL_MIN,
				bgcm_pkg::ST_SAT},
			'{bgcm_pkg::ACT_L2P, AX_Y, 0, bgcm_pkg::ONE_Q, 1, bgcm_pkg::VAL_MAX, bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_P2L, AX_X, 0, bgcm_pkg::ZERO_Q, 1, 32'h0000_8000, bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_P2L, AX_X, 0, 32'hFFFF_0000, 1, bgcm_pkg::ZERO_Q, bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_P2L, AX_X, 0, bgcm_pkg::ONE_Q, 1, bgcm_pkg::ONE_Q, bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_P2L, AX_X, 0, bgcm_pkg::VAL_MAX, 0, bgcm_pkg::ZERO_Q, bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_P2L, AX_X, 0, bgcm_pkg::VAL_MIN, 0, bgcm_pkg::ZERO_Q, bgcm_pkg::ST_OK},
			'{bgcm_pkg::ACT_P2L, AX_Z, 0, bgcm_pkg::ZERO_Q, 1, bgcm_pkg::VAL_MAX,
				bgcm_pkg::ST_SAT},
			'{bgcm_pkg::ACT_P2L, AX_Z, 0, 32'h0000_0005, 1, bgcm_pkg::VAL_MAX, bgcm_pkg::ST_SAT},
			'{bgcm_pkg::ACT_P2L, AX_Z, 0, 32'hFFFF_FFFB, 1, bgcm_pkg::VAL_MIN, bgcm_pkg::ST_SAT},
			'{bgcm_pkg::ACT_L2P, AX_Z, 0, 32'h0000_9C40, 1, bgcm_pkg::ZERO_Q, bgcm_pkg::ST_OK}
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[r]) send_beat(rows[r]);
		drain();
		for (int ph = 0; ph < 7; ph++) begin
			steady <= (ph % 3 == 2);
			write_points(bgcm_pkg::REG_POINTS_X, setups[ph][0]);
			write_points(bgcm_pkg::REG_POINTS_Y, setups[ph][1]);
			write_points(bgcm_pkg::REG_POINTS_Z, setups[ph][2]);
			if (ph == 1) long_hold <= 1'b1;
			load_axes(ph == 4);
			repeat (30) random_item();
			drain();
		end
		repeat (60) @(posedge clk);
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
